FILE: rtl/fgn_pkg.sv
// Shared types, register indexes, the permutation table and helper functions for the fractal gradient noise block.
package fgn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int PROD_W          = 40;

    localparam logic [3:0] CFG_OCTAVE_COUNT   = 4'd0;
    localparam logic [3:0] CFG_BASE_FREQUENCY = 4'd1;
    localparam logic [3:0] CFG_BASE_AMPLITUDE = 4'd2;
    localparam logic [3:0] CFG_PERSISTENCE    = 4'd3;

    // point scaled by the base frequency (low 40 bits), running sum and weight
    typedef struct packed {
        logic [PROD_W-1:0] prod_x;
        logic [PROD_W-1:0] prod_y;
        logic [PROD_W-1:0] prod_z;
        logic [23:0]       sum;
        logic [23:0]       ampl;
    } t_link;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    function automatic logic signed [19:0] grad3(input logic [3:0] h,
                                                 input logic signed [19:0] x,
                                                 input logic signed [19:0] y,
                                                 input logic signed [19:0] z);
        logic signed [19:0] u;
        logic signed [19:0] v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // a + floor(t*(b-a) / 2^16)
    function automatic logic signed [19:0] lerp16(input logic [16:0] t,
                                                  input logic signed [19:0] a,
                                                  input logic signed [19:0] b);
        logic signed [20:0] d;
        logic signed [38:0] p;
        d = $signed({b[19], b}) - $signed({a[19], a});
        p = $signed({1'b0, t}) * d;
        return a + 20'(p >>> 16);
    endfunction

endpackage

FILE: rtl/fractal_gradient_noise_3d.sv
// Start is registered, then each point passes through the MAX_OCTAVES octave cells in turn to o_valid.
// Throughput: one point per cycle; busy stays low, every octave cell is its own
// eight-stage pipeline and the cells hand each point on every cycle.
// Results show for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset clears the pipeline valids and loads register defaults:
// 2 octaves, frequency 1.0, amplitude 1.0, persistence 1.0.
module fractal_gradient_noise_3d #(
    parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    output logic        o_valid,
    output logic [23:0] o_noise_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import fgn_pkg::*;

    logic [3:0]  r_octave_count;
    logic [23:0] r_base_frequency;
    logic [23:0] r_base_amplitude;
    logic [17:0] r_persistence;

    logic        r_vld0;
    t_link       r_link0;

    logic [56:0] w_mx, w_my, w_mz;
    logic        w_vld  [MAX_OCTAVES+1];
    t_link       w_link [MAX_OCTAVES+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count   <= 4'd2;
            r_base_frequency <= 24'd65536;
            r_base_amplitude <= 24'd65536;
            r_persistence    <= 18'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OCTAVE_COUNT:   r_octave_count   <= i_cfg_data[3:0];
                CFG_BASE_FREQUENCY: r_base_frequency <= i_cfg_data;
                CFG_BASE_AMPLITUDE: r_base_amplitude <= i_cfg_data;
                CFG_PERSISTENCE:    r_persistence    <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // coordinate times frequency; the low 40 bits cover every octave's window
    assign w_mx = $signed(i_coord_x) * $signed({1'b0, r_base_frequency});
    assign w_my = $signed(i_coord_y) * $signed({1'b0, r_base_frequency});
    assign w_mz = $signed(i_coord_z) * $signed({1'b0, r_base_frequency});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link0.prod_x <= w_mx[PROD_W-1:0];
        r_link0.prod_y <= w_my[PROD_W-1:0];
        r_link0.prod_z <= w_mz[PROD_W-1:0];
        r_link0.sum    <= '0;
        r_link0.ampl   <= r_base_amplitude;
    end

    assign w_vld[0]  = r_vld0;
    assign w_link[0] = r_link0;

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
        fgn_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_vld          (w_vld[k]),
            .i_link         (w_link[k]),
            .i_octave_count (r_octave_count),
            .i_persistence  (r_persistence),
            .o_vld          (w_vld[k+1]),
            .o_link         (w_link[k+1])
        );
    end

    assign o_valid       = w_vld[MAX_OCTAVES];
    assign o_noise_value = w_link[MAX_OCTAVES].sum;

endmodule

FILE: rtl/fgn_cell.sv
// One octave cell: eight-stage noise evaluation, weighting and accumulation.
module fgn_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  fgn_pkg::t_link i_link,
    input  logic [3:0]     i_octave_count,
    input  logic [17:0]    i_persistence,
    output logic           o_vld,
    output fgn_pkg::t_link o_link
);
    import fgn_pkg::*;

    localparam int LO  = 16 - IDX;
    localparam int DLY = 7;

    logic [DLY-1:0]     r_vld;
    t_link              r_link [DLY];
    logic               r_ovld;
    t_link              r_olink;

    logic [23:0]        w_p   [3];
    logic [31:0]        w_sq  [3];
    logic [15:0]        r1_f  [3];
    logic [15:0]        r1_q  [3];
    logic [7:0]         r1_a, r1_b, r1_cz;

    logic [31:0]        w_cub [3];
    logic [20:0]        w_in  [3];
    logic [15:0]        r2_f  [3];
    logic [15:0]        r2_c  [3];
    logic [20:0]        r2_in [3];
    logic [7:0]         r2_aa, r2_ab, r2_ba, r2_bb;

    logic [36:0]        w_fd  [3];
    logic signed [19:0] w_o0  [3];
    logic signed [19:0] w_o1  [3];
    logic [16:0]        r3_fade [3];
    logic signed [19:0] r3_g  [8];

    logic signed [19:0] r4_l  [4];
    logic [16:0]        r4_v, r4_w;
    logic signed [19:0] r5_r0, r5_r1;
    logic [16:0]        r5_w;
    logic signed [19:0] w_r;
    logic [19:0]        r6_mag;

    logic [43:0]        w_term;
    logic [41:0]        w_amp;
    logic [27:0]        r7_term;
    logic [25:0]        r7_amp;

    logic               w_active;
    logic [28:0]        n_sum;

    assign w_p[0] = i_link.prod_x[LO+23:LO];
    assign w_p[1] = i_link.prod_y[LO+23:LO];
    assign w_p[2] = i_link.prod_z[LO+23:LO];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i]  = w_p[i][15:0] * w_p[i][15:0];
            w_cub[i] = r1_q[i] * r1_f[i];
            w_in[i]  = 21'(r1_q[i]) * 21'd6 + 21'd655360 - 21'(r1_f[i]) * 21'd15;
            w_fd[i]  = 37'(r2_c[i]) * 37'(r2_in[i]);
            w_o0[i]  = $signed({4'b0, r2_f[i]});
            w_o1[i]  = w_o0[i] - 20'sd65536;
        end
    end

    assign w_r      = lerp16(r5_w, r5_r0, r5_r1);
    assign w_term   = 44'(r6_mag) * 44'(r_link[5].ampl);
    assign w_amp    = 42'(r_link[5].ampl) * 42'(i_persistence);
    assign w_active = 4'(IDX) < i_octave_count;
    assign n_sum    = 29'(r_link[6].sum) + 29'(r7_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[DLY-2:0], i_vld};
            r_ovld <= r_vld[DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_link[0] <= i_link;
        for (int j = 1; j < DLY; j++) begin
            r_link[j] <= r_link[j-1];
        end

        // stage 1: squares, first hash level
        for (int i = 0; i < 3; i++) begin
            r1_f[i] <= w_p[i][15:0];
            r1_q[i] <= w_sq[i][31:16];
        end
        r1_a  <= PERM_ROM[w_p[0][23:16]] + w_p[1][23:16];
        r1_b  <= PERM_ROM[w_p[0][23:16] + 8'd1] + w_p[1][23:16];
        r1_cz <= w_p[2][23:16];

        // stage 2: cubes and fade polynomial, second hash level
        for (int i = 0; i < 3; i++) begin
            r2_f[i]  <= r1_f[i];
            r2_c[i]  <= w_cub[i][31:16];
            r2_in[i] <= w_in[i];
        end
        r2_aa <= PERM_ROM[r1_a] + r1_cz;
        r2_ab <= PERM_ROM[r1_a + 8'd1] + r1_cz;
        r2_ba <= PERM_ROM[r1_b] + r1_cz;
        r2_bb <= PERM_ROM[r1_b + 8'd1] + r1_cz;

        // stage 3: fade weights and the eight corner gradients
        for (int i = 0; i < 3; i++) begin
            r3_fade[i] <= w_fd[i][32:16];
        end
        r3_g[0] <= grad3(PERM_ROM[r2_aa][3:0], w_o0[0], w_o0[1], w_o0[2]);
        r3_g[1] <= grad3(PERM_ROM[r2_ba][3:0], w_o1[0], w_o0[1], w_o0[2]);
        r3_g[2] <= grad3(PERM_ROM[r2_ab][3:0], w_o0[0], w_o1[1], w_o0[2]);
        r3_g[3] <= grad3(PERM_ROM[r2_bb][3:0], w_o1[0], w_o1[1], w_o0[2]);
        r3_g[4] <= grad3(PERM_ROM[r2_aa + 8'd1][3:0], w_o0[0], w_o0[1], w_o1[2]);
        r3_g[5] <= grad3(PERM_ROM[r2_ba + 8'd1][3:0], w_o1[0], w_o0[1], w_o1[2]);
        r3_g[6] <= grad3(PERM_ROM[r2_ab + 8'd1][3:0], w_o0[0], w_o1[1], w_o1[2]);
        r3_g[7] <= grad3(PERM_ROM[r2_bb + 8'd1][3:0], w_o1[0], w_o1[1], w_o1[2]);

        // stages 4 to 6: interpolate along x, y, z; stage 6 also takes the magnitude
        r4_l[0] <= lerp16(r3_fade[0], r3_g[0], r3_g[1]);
        r4_l[1] <= lerp16(r3_fade[0], r3_g[2], r3_g[3]);
        r4_l[2] <= lerp16(r3_fade[0], r3_g[4], r3_g[5]);
        r4_l[3] <= lerp16(r3_fade[0], r3_g[6], r3_g[7]);
        r4_v    <= r3_fade[1];
        r4_w    <= r3_fade[2];

        r5_r0 <= lerp16(r4_v, r4_l[0], r4_l[1]);
        r5_r1 <= lerp16(r4_v, r4_l[2], r4_l[3]);
        r5_w  <= r4_w;

        r6_mag <= w_r[19] ? 20'(-w_r) : 20'(w_r);

        // stage 7: weight the magnitude, step the amplitude
        r7_term <= w_term[43:16];
        r7_amp  <= w_amp[41:16];

        // stage 8: saturating accumulate in active octaves, saturate the stepped amplitude
        r_olink <= r_link[6];
        if (w_active) begin
            r_olink.sum <= (n_sum > 29'hFFFFFF) ? 24'hFFFFFF : n_sum[23:0];
        end
        r_olink.ampl <= (r7_amp > 26'hFFFFFF) ? 24'hFFFFFF : r7_amp[23:0];
    end

    assign o_vld  = r_ovld;
    assign o_link = r_olink;

endmodule

FILE: sim/tb_fractal_gradient_noise_3d.sv
// Self-checking testbench for the fractal gradient noise block: directed table, random phases.
module tb_fractal_gradient_noise_3d;
    timeunit 1ns;
    timeprecision 1ps;
    import fgn_pkg::*;

    localparam int          NOISE_OCTAVE_LIMIT = 8;
    localparam logic [3:0]  CFG_UNMAPPED       = 4'd9;
    localparam int          PHASE_ITEMS        = 180;
    localparam int          RANDOM_PHASES      = 8;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          fixed;
        logic [23:0] value;
    } t_point_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_coord_x = '0;
    logic [31:0] i_coord_y = '0;
    logic [31:0] i_coord_z = '0;
    logic        o_valid;
    logic [23:0] o_noise_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    // shadow of the block's registers
    logic [3:0]  octaves_q;
    logic [23:0] frequency_q;
    logic [23:0] amplitude_q;
    logic [17:0] persistence_q;

    logic [23:0] noise_expected[$];
    int          mismatches = 0;
    int          burst_left = 0;

    fractal_gradient_noise_3d dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int unsigned perm(int unsigned i);
        return PERM_ROM[i & 255];
    endfunction

    function automatic longint fade_q16(longint unsigned f);
        longint unsigned q, c, inner;
        q = (f * f) >> 16;
        c = (q * f) >> 16;
        inner = (6 * q + 655360) - 15 * f;
        return longint'((c * inner) >> 16);
    endfunction

    function automatic longint blend(longint t, longint a, longint b);
        return a + ((t * (b - a)) >>> 16);
    endfunction

    function automatic longint corner_grad(int unsigned hash, longint x, longint y, longint z);
        int unsigned h;
        longint u, v;
        h = hash & 15;
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    function automatic longint unsigned octave_abs(logic [23:0] px, logic [23:0] py,
                                                   logic [23:0] pz);
        int unsigned cx, cy, cz, a, aa, ab, b, ba, bb;
        longint x, y, z, x1, y1, z1, u, v, w, r0, r1, r;
        cx = px[23:16]; cy = py[23:16]; cz = pz[23:16];
        x = px[15:0]; y = py[15:0]; z = pz[15:0];
        u = fade_q16(x); v = fade_q16(y); w = fade_q16(z);
        a = perm(cx) + cy; aa = perm(a) + cz; ab = perm(a + 1) + cz;
        b = perm(cx + 1) + cy; ba = perm(b) + cz; bb = perm(b + 1) + cz;
        x1 = x - 65536; y1 = y - 65536; z1 = z - 65536;
        r0 = blend(v,
            blend(u, corner_grad(perm(aa), x, y, z), corner_grad(perm(ba), x1, y, z)),
            blend(u, corner_grad(perm(ab), x, y1, z), corner_grad(perm(bb), x1, y1, z)));
        r1 = blend(v,
            blend(u, corner_grad(perm(aa + 1), x, y, z1),
                     corner_grad(perm(ba + 1), x1, y, z1)),
            blend(u, corner_grad(perm(ab + 1), x, y1, z1),
                     corner_grad(perm(bb + 1), x1, y1, z1)));
        r = blend(w, r0, r1);
        return longint'(r < 0 ? -r : r);
    endfunction

    function automatic logic [23:0] fractal_noise(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
        logic [63:0] sx, sy, sz, sum, ampl;
        int n;
        sx = {{32{x[31]}}, x}; sy = {{32{y[31]}}, y}; sz = {{32{z[31]}}, z};
        sum = 0;
        ampl = amplitude_q;
        n = (octaves_q > NOISE_OCTAVE_LIMIT) ? NOISE_OCTAVE_LIMIT : octaves_q;
        for (int k = 0; k < n; k++) begin
            sum += (octave_abs(24'(((sx * frequency_q) << k) >> 16),
                               24'(((sy * frequency_q) << k) >> 16),
                               24'(((sz * frequency_q) << k) >> 16)) * ampl) >> 16;
            if (sum > 64'hFFFFFF) sum = 64'hFFFFFF;
            ampl = (ampl * persistence_q) >> 16;
            if (ampl > 64'hFFFFFF) ampl = 64'hFFFFFF;
        end
        return sum[23:0];
    endfunction

    // leaves valid high so back-to-back writes need no lowering in the same step
    task automatic reg_write(logic [3:0] idx, logic [23:0] data);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
            if (ok) break;
        end
        case (idx)
            CFG_OCTAVE_COUNT:   octaves_q = data[3:0];
            CFG_BASE_FREQUENCY: frequency_q = data;
            CFG_BASE_AMPLITUDE: amplitude_q = data;
            CFG_PERSISTENCE:    persistence_q = data[17:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [3:0] oct, logic [23:0] freq, logic [23:0] amp,
                                 logic [23:0] pers);
        reg_write(CFG_OCTAVE_COUNT, {20'd0, oct});
        reg_write(CFG_BASE_FREQUENCY, freq);
        reg_write(CFG_BASE_AMPLITUDE, amp);
        reg_write(CFG_PERSISTENCE, pers);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit fixed, logic [23:0] value);
        bit ok;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        start     <= 1'b1;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        forever begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
            if (ok) break;
        end
        noise_expected.push_back(fixed ? value : fractal_noise(x, y, z));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (noise_expected.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h000F_FFFF) * (($urandom_range(0, 1)) ? 1 : -1);
            2: return {$urandom_range(0, 65535), 16'h0000} | ($urandom_range(0, 1) << 15);
            default: return $urandom_range(0, 1) ? 32'h7FFF_0000 | $urandom_range(0, 65535)
                                                 : 32'h8000_0000 | $urandom_range(0, 65535);
        endcase
    endfunction

    always @(negedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n && o_valid) begin
            if (noise_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result noise_value=%h", o_noise_value);
            end else begin
                want = noise_expected.pop_front();
                if (o_noise_value !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_value mismatch: expected %h actual %h",
                                 want, o_noise_value);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_fractal_gradient_noise_3d failed");
        $finish;
    end

    initial begin
        t_point_row rows[$];
        octaves_q = 4'd2; frequency_q = 24'h010000; amplitude_q = 24'h010000;
        persistence_q = 18'h10000;
        // the four lattice points give zero noise under the reset settings; other rows use the model
        rows = '{
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 24'd0},
            '{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1, 24'd0},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 24'd0},
            '{32'h7FFF_0000, 32'h8000_0000, 32'h0000_0000, 1, 24'd0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 24'd0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 24'd0},
            '{32'h8000_0001, 32'h7FFF_FFFF, 32'h0000_0001, 0, 24'd0},
            '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 24'd0},
            '{32'hFFFF_8000, 32'h0001_4000, 32'h0002_C000, 0, 24'd0},
            '{32'h0000_FFFF, 32'h0000_0001, 32'hFFFF_0001, 0, 24'd0},
            '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0, 0, 24'd0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 32'h00FF_FF00, 0, 24'd0},
            '{32'h0003_2AB0, 32'hFFFE_1234, 32'h0000_3FFF, 0, 24'd0},
            '{32'h00FF_C000, 32'h0100_4000, 32'hFF00_2000, 0, 24'd0}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].fixed,
                                     rows[i].value);
        drain();
        // valid stays high; the first phase's writes follow directly
        reg_write(CFG_UNMAPPED, 24'hFFFFFF);
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: load_settings(4'd0, 24'h010000, 24'h010000, 24'h010000);
                1: load_settings(4'd8, 24'hFFFFFF, 24'hFFFFFF, 24'h03FFFF);
                2: load_settings(4'd15, 24'h010000, 24'h010000, 24'h010000);
                3: load_settings(4'd1, 24'h000000, 24'h000000, 24'h000000);
                4: load_settings(4'd8, 24'h000001, 24'h800000, 24'h008000);
                default: load_settings(4'($urandom_range(0, 15)),
                                       24'($urandom_range(0, 24'h03FFFF)),
                                       24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_point(pick_coord(), pick_coord(), pick_coord(), 0, 24'd0);
            drain();
        end
        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && noise_expected.size() == 0)
            $display("tb_fractal_gradient_noise_3d passed");
        else
            $display("tb_fractal_gradient_noise_3d failed");
        $finish;
    end

endmodule
